### rtl/msgp_pkg.sv
// shared types, constants and helpers for the message packetizer
package msgp_pkg;

    localparam int HDR_BYTES = 24;
    localparam logic [4:0] HDR_LAST = 5'(HDR_BYTES);
    localparam logic [7:0] SRC_PORT = 8'd32;
    localparam logic [7:0] DST_PORT = 8'd64;
    localparam logic [32:0] CHECK_MOD = 33'h0FFFFFFFF;

    typedef enum logic [2:0] {
        REG_MAX_PAYLOAD = 3'd0,
        REG_MAX_PACKETS = 3'd1,
        REG_SRC_ADDR    = 3'd2,
        REG_DST_ADDR    = 3'd3,
        REG_HDR_FLAGS   = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic        start_of_message;
        logic [23:0] message_length;
        logic [7:0]  data_byte;
    } msg_item_t;

    typedef struct packed {
        logic [7:0]  packet_byte;
        logic        end_of_packet;
        logic        end_of_run;
        logic [15:0] packet_number;
    } pkt_item_t;

    typedef struct packed {
        logic [15:0] payload_limit;
        logic [15:0] max_packets;
        logic [39:0] source_address;
        logic [39:0] destination_address;
        logic [15:0] header_flags;
    } cfg_t;

    typedef struct packed {
        logic        is_header;
        logic [7:0]  data_byte;
        logic        eop;
        logic [15:0] pnum;
        logic [15:0] size;
    } job_t;

    typedef struct packed {
        logic [23:0] offset;
        logic [31:0] checksum;
    } chk_t;

    function automatic logic [15:0] eff_payload(input logic [15:0] payload_limit);
        eff_payload = (payload_limit == 16'd0) ? 16'd1 : payload_limit;
    endfunction

endpackage

### rtl/message_packetizer.sv
// message packetizer top level
//
// msg channel: one message byte per transfer (msg_valid / msg_stall). The
// first byte of a message has start_of_message set and carries the message
// length. pkt channel: one packet byte per transfer (pkt_valid / pkt_stall).
// cfg channel: register writes (cfg_valid / cfg_ready), index 0 max payload,
// 1 max packets, 2 source address, 3 destination address, 4 header flags;
// other indexes are ignored. cfg_ready is always high.
// A byte that opens a fragment produces a 24-byte header and then the byte:
// the input stalls while the header sequencer steps through the header.
// Other bytes are taken back to back unless the output stalls. A msg
// transfer passes through the job register and then the output register
// before its first pkt byte. Offset and checksum come from a five-stage
// pipeline that finishes before the header reaches those bytes.
// A stalled receiver holds the output register; the job register then fills
// and msg_stall rises. Reset clears all counters and restores register
// defaults; no transfer is pending after reset.
module message_packetizer
    import msgp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        msg_valid,
    output logic        msg_stall,
    input  msg_item_t   msg_item,
    output logic        pkt_valid,
    input  logic        pkt_stall,
    output pkt_item_t   pkt_item,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [39:0] cfg_data
);

    cfg_t cfg;
    job_t job;
    chk_t chk;
    logic job_valid;
    logic job_done;

    msgp_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    msgp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .msg_valid (msg_valid),
        .msg_stall (msg_stall),
        .msg_item  (msg_item),
        .job_done  (job_done),
        .job_valid (job_valid),
        .job       (job)
    );

    msgp_chk u_chk (
        .clk (clk),
        .cfg (cfg),
        .job (job),
        .chk (chk)
    );

    msgp_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .job_valid (job_valid),
        .job       (job),
        .chk       (chk),
        .job_done  (job_done),
        .pkt_valid (pkt_valid),
        .pkt_stall (pkt_stall),
        .pkt_item  (pkt_item)
    );

endmodule

### rtl/msgp_cfg.sv
// configuration register file
module msgp_cfg
    import msgp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [39:0] cfg_data,
    output cfg_t        cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_MAX_PAYLOAD: cfg_next.payload_limit = cfg_data[15:0];
                REG_MAX_PACKETS: cfg_next.max_packets = cfg_data[15:0];
                REG_SRC_ADDR:    cfg_next.source_address = cfg_data;
                REG_DST_ADDR:    cfg_next.destination_address = cfg_data;
                REG_HDR_FLAGS:   cfg_next.header_flags = cfg_data[15:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.payload_limit <= 16'd1024;
            cfg_reg.max_packets <= 16'hFFFF;
            cfg_reg.source_address <= 40'd0;
            cfg_reg.destination_address <= 40'd0;
            cfg_reg.header_flags <= 16'd0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

### rtl/msgp_ctrl.sv
// message and fragment counters, job register for the emitter
module msgp_ctrl
    import msgp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    input  logic      msg_valid,
    output logic      msg_stall,
    input  msg_item_t msg_item,
    input  logic      job_done,
    output logic      job_valid,
    output job_t      job
);

    logic [23:0] br_reg, br_next;
    logic [15:0] fbl_reg, fbl_next;
    logic [15:0] pm_reg, pm_next;
    logic        job_valid_reg, job_valid_next;
    job_t        job_reg, job_next;

    logic        accept;
    logic [23:0] br;
    logic [15:0] fbl;
    logic [15:0] pm;
    logic [15:0] mp;
    logic [15:0] size;

    assign msg_stall = job_valid_reg && !job_done;
    assign accept = msg_valid && !msg_stall;
    assign job_valid = job_valid_reg;
    assign job = job_reg;

    always_comb
    begin
        br = msg_item.start_of_message ? msg_item.message_length : br_reg;
        fbl = msg_item.start_of_message ? 16'd0 : fbl_reg;
        pm = msg_item.start_of_message ? 16'd0 : pm_reg;
        mp = eff_payload(cfg.payload_limit);
        size = (br < {8'd0, mp}) ? br[15:0] : mp;

        br_next = br_reg;
        fbl_next = fbl_reg;
        pm_next = pm_reg;
        job_valid_next = job_valid_reg && !job_done;
        job_next = job_reg;

        if (accept)
        begin
            br_next = br;
            fbl_next = fbl;
            pm_next = pm;
            job_next.data_byte = msg_item.data_byte;
            if (br != 24'd0)
            begin
                if (fbl == 16'd0)
                begin
                    if (pm < cfg.max_packets)
                    begin
                        br_next = br - 24'd1;
                        fbl_next = size - 16'd1;
                        pm_next = pm + 16'd1;
                        job_next.is_header = 1'b1;
                        job_next.pnum = pm;
                        job_next.size = size;
                        job_next.eop = (size == 16'd1);
                        job_valid_next = 1'b1;
                    end
                end
                else
                begin
                    br_next = br - 24'd1;
                    fbl_next = fbl - 16'd1;
                    job_next.is_header = 1'b0;
                    job_next.pnum = pm - 16'd1;
                    job_next.size = fbl;
                    job_next.eop = (fbl == 16'd1);
                    job_valid_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            br_reg <= 24'd0;
            fbl_reg <= 16'd0;
            pm_reg <= 16'd0;
            job_valid_reg <= 1'b0;
        end
        else
        begin
            br_reg <= br_next;
            fbl_reg <= fbl_next;
            pm_reg <= pm_next;
            job_valid_reg <= job_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
    end

endmodule

### rtl/msgp_chk.sv
// fragment offset and header checksum pipeline
module msgp_chk
    import msgp_pkg::*;
(
    input  logic clk,
    input  cfg_t cfg,
    input  job_t job,
    output chk_t chk
);

    logic [31:0] prod_reg, prod_next;
    logic [40:0] addr_reg, addr_next;
    logic [17:0] misc_reg, misc_next;
    logic [24:0] part_reg, part_next;
    logic [41:0] total_reg, total_next;
    logic [32:0] fold_reg, fold_next;
    logic [31:0] sum_reg, sum_next;

    always_comb
    begin
        prod_next = 32'(job.pnum) * 32'(eff_payload(cfg.payload_limit));
        addr_next = 41'(cfg.source_address) + 41'(cfg.destination_address);
        misc_next = 18'(cfg.header_flags) + 18'(job.size)
                  + 18'(SRC_PORT) + 18'(DST_PORT) + 18'(HDR_BYTES);
        part_next = 25'(prod_reg[23:0]) + 25'(misc_reg);
        total_next = 42'(addr_reg) + 42'(part_reg);
        fold_next = 33'(total_reg[41:32]) + 33'(total_reg[31:0]);
        sum_next = (fold_reg >= CHECK_MOD) ? 32'(fold_reg - CHECK_MOD) : fold_reg[31:0];
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        addr_reg <= addr_next;
        misc_reg <= misc_next;
        part_reg <= part_next;
        total_reg <= total_next;
        fold_reg <= fold_next;
        sum_reg <= sum_next;
    end

    assign chk.offset = prod_reg[23:0];
    assign chk.checksum = sum_reg;

endmodule

### rtl/msgp_emit.sv
// header sequencer and output register
module msgp_emit
    import msgp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    input  logic      job_valid,
    input  job_t      job,
    input  chk_t      chk,
    output logic      job_done,
    output logic      pkt_valid,
    input  logic      pkt_stall,
    output pkt_item_t pkt_item
);

    logic [4:0] idx_reg, idx_next;
    logic       pkt_valid_reg, pkt_valid_next;
    pkt_item_t  pkt_item_reg, pkt_item_next;

    logic [HDR_BYTES-1:0][7:0] hdr;
    logic [23:0] len;
    logic [4:0]  sel;
    logic        load;
    logic        last;

    assign len = 24'(job.size) + 24'(HDR_BYTES);
    assign hdr = {cfg.source_address, cfg.destination_address, SRC_PORT, DST_PORT,
                  chk.offset, cfg.header_flags, len, chk.checksum};
    assign sel = 5'(HDR_BYTES - 1) - idx_reg;

    always_comb
    begin
        load = job_valid && (!pkt_valid_reg || !pkt_stall);
        last = !job.is_header || (idx_reg == HDR_LAST);
        job_done = load && last;

        pkt_item_next = pkt_item_reg;
        idx_next = idx_reg;
        pkt_valid_next = pkt_valid_reg && pkt_stall;

        if (load)
        begin
            pkt_valid_next = 1'b1;
            pkt_item_next.packet_number = job.pnum;
            if (last)
            begin
                pkt_item_next.packet_byte = job.data_byte;
                pkt_item_next.end_of_packet = job.eop;
                pkt_item_next.end_of_run = 1'b1;
                idx_next = 5'd0;
            end
            else
            begin
                pkt_item_next.packet_byte = hdr[sel];
                pkt_item_next.end_of_packet = 1'b0;
                pkt_item_next.end_of_run = 1'b0;
                idx_next = idx_reg + 5'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= 5'd0;
            pkt_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg <= idx_next;
            pkt_valid_reg <= pkt_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pkt_item_reg <= pkt_item_next;
    end

    assign pkt_valid = pkt_valid_reg;
    assign pkt_item = pkt_item_reg;

`ifndef ASSERT_OFF
    a_idx_header: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg != 5'd0 |-> (job_valid && job.is_header))
        else $error("header sequencer running without a header job");

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= HDR_LAST)
        else $error("header byte index out of range");

    a_mid_header: assert property (@(posedge clk) disable iff (!rst_n)
        (pkt_valid_reg && !pkt_item_reg.end_of_run) |-> idx_reg != 5'd0)
        else $error("header byte pending but sequencer is idle");

    a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> pkt_valid_reg)
        else $error("loaded byte not presented");
`endif

endmodule

### bench/testbench.sv
// self-checking testbench for the message packetizer: random messages, settings and stalls
module testbench;
    import msgp_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int SETTLE_CYCLES = 40;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS = 24;
    localparam logic [2:0] REG_SPARE_LO = 3'd5;
    localparam logic [2:0] REG_SPARE_HI = 3'd7;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic msg_valid = 1'b0;
    logic msg_stall;
    msg_item_t msg_item = '0;
    logic pkt_valid;
    logic pkt_stall = 1'b0;
    pkt_item_t pkt_item;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [2:0] cfg_index = '0;
    logic [39:0] cfg_data = '0;

    message_packetizer uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .msg_valid (msg_valid),
        .msg_stall (msg_stall),
        .msg_item  (msg_item),
        .pkt_valid (pkt_valid),
        .pkt_stall (pkt_stall),
        .pkt_item  (pkt_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    // predictor state and register copy
    cfg_t pk_cfg;
    logic [23:0] bytes_left;
    logic [15:0] frag_left;
    logic [23:0] frag_offset;
    logic [15:0] packets_made;

    msg_item_t msg_backlog[$];
    pkt_item_t expected_bytes[$];
    pkt_item_t want_byte;

    int items_queued = 0;
    int items_accepted = 0;
    int bytes_checked = 0;
    int headers_predicted = 0;
    int messages_started = 0;
    int settings_applied = 0;
    int mismatches = 0;
    int cycles = 0;
    int gap_left = 0;
    int stall_left = 0;
    bit bursts_on = 1'b1;

    task automatic packetize_byte(input msg_item_t it);
        logic [15:0] mp;
        logic [15:0] size;
        logic [23:0] offset;
        logic [23:0] plen;
        logic [63:0] sum;
        logic [191:0] hdr;
        pkt_item_t r;
        int i;
        if (it.start_of_message) begin
            bytes_left = it.message_length;
            frag_left = '0;
            frag_offset = '0;
            packets_made = '0;
            messages_started++;
        end
        if (bytes_left == 0)
            return;
        if (frag_left == 0) begin
            if (packets_made >= pk_cfg.max_packets)
                return;
            mp = (pk_cfg.payload_limit == 0) ? 16'd1 : pk_cfg.payload_limit;
            size = (bytes_left < 24'(mp)) ? bytes_left[15:0] : mp;
            plen = 24'(HDR_BYTES) + 24'(size);
            offset = 24'(32'(packets_made) * 32'(mp));
            frag_offset = offset;
            sum = 64'(pk_cfg.source_address) + 64'(pk_cfg.destination_address)
                + 64'(SRC_PORT) + 64'(DST_PORT) + 64'(offset)
                + 64'(pk_cfg.header_flags) + 64'(plen);
            sum = sum % 64'(CHECK_MOD);
            hdr = {pk_cfg.source_address, pk_cfg.destination_address, SRC_PORT, DST_PORT,
                   offset, pk_cfg.header_flags, plen, sum[31:0]};
            for (i = 0; i < HDR_BYTES; i++) begin
                r.packet_byte = hdr[191 - 8 * i -: 8];
                r.end_of_packet = 1'b0;
                r.end_of_run = 1'b0;
                r.packet_number = packets_made;
                expected_bytes.push_back(r);
            end
            frag_left = size;
            packets_made = packets_made + 16'd1;
            headers_predicted++;
        end
        bytes_left = bytes_left - 24'd1;
        frag_left = frag_left - 16'd1;
        r.packet_byte = it.data_byte;
        r.end_of_packet = (frag_left == 0);
        r.end_of_run = 1'b1;
        r.packet_number = packets_made - 16'd1;
        expected_bytes.push_back(r);
    endtask

    // message driver
    always @(posedge clk) begin
        if (!rst_n) begin
            msg_valid <= 1'b0;
        end
        else begin
            if (msg_valid && !msg_stall) begin
                packetize_byte(msg_item);
                items_accepted++;
            end
            if (!msg_valid || !msg_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    msg_valid <= 1'b0;
                end
                else if (bursts_on && $urandom_range(0, 7) == 0) begin
                    gap_left = $urandom_range(1, 9) - 1;
                    msg_valid <= 1'b0;
                end
                else if (msg_backlog.size() > 0) begin
                    msg_item <= msg_backlog.pop_front();
                    msg_valid <= 1'b1;
                end
                else begin
                    msg_valid <= 1'b0;
                end
            end
        end
    end

    // packet monitor
    always @(posedge clk) begin
        if (!rst_n) begin
            pkt_stall <= 1'b0;
        end
        else begin
            if (pkt_valid && !pkt_stall) begin
                if (expected_bytes.size() == 0) begin
                    $error("packet byte %h arrived with nothing expected", pkt_item.packet_byte);
                    mismatches++;
                end
                else begin
                    want_byte = expected_bytes.pop_front();
                    bytes_checked++;
                    if (pkt_item.packet_byte !== want_byte.packet_byte) begin
                        $error("packet_byte: expected %h, got %h",
                               want_byte.packet_byte, pkt_item.packet_byte);
                        mismatches++;
                    end
                    if (pkt_item.end_of_packet !== want_byte.end_of_packet) begin
                        $error("end_of_packet: expected %b, got %b",
                               want_byte.end_of_packet, pkt_item.end_of_packet);
                        mismatches++;
                    end
                    if (pkt_item.end_of_run !== want_byte.end_of_run) begin
                        $error("end_of_run: expected %b, got %b",
                               want_byte.end_of_run, pkt_item.end_of_run);
                        mismatches++;
                    end
                    if (pkt_item.packet_number !== want_byte.packet_number) begin
                        $error("packet_number: expected %0d, got %0d",
                               want_byte.packet_number, pkt_item.packet_number);
                        mismatches++;
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                pkt_stall <= 1'b1;
            end
            else if (bursts_on && $urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(1, 9) - 1;
                pkt_stall <= 1'b1;
            end
            else begin
                pkt_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("[message_packetizer] ERROR");
            $finish;
        end
    end

    task automatic queue_bytes(input logic som, input logic [23:0] len, input int count);
        msg_item_t it;
        int i;
        for (i = 0; i < count; i++) begin
            it.start_of_message = som && (i == 0);
            it.message_length = it.start_of_message ? len : 24'($urandom);
            it.data_byte = 8'($urandom);
            msg_backlog.push_back(it);
            items_queued++;
        end
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [39:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_MAX_PAYLOAD: pk_cfg.payload_limit = data[15:0];
            REG_MAX_PACKETS: pk_cfg.max_packets = data[15:0];
            REG_SRC_ADDR:    pk_cfg.source_address = data;
            REG_DST_ADDR:    pk_cfg.destination_address = data;
            REG_HDR_FLAGS:   pk_cfg.header_flags = data[15:0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(input logic [39:0] pay, input logic [39:0] pkts,
                                  input logic [39:0] src, input logic [39:0] dst,
                                  input logic [39:0] flags);
        write_reg(REG_MAX_PAYLOAD, pay);
        write_reg(REG_MAX_PACKETS, pkts);
        write_reg(REG_SRC_ADDR, src);
        write_reg(REG_DST_ADDR, dst);
        write_reg(REG_HDR_FLAGS, flags);
        cfg_valid <= 1'b0;
        settings_applied++;
    endtask

    task automatic drain;
        while (items_accepted != items_queued || expected_bytes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [39:0] pick_addr();
        return ($urandom_range(0, 5) == 0) ? '1 : {8'($urandom), 32'($urandom)};
    endfunction

    task automatic random_phase(input int phase);
        logic [15:0] pay;
        logic [15:0] pkts;
        int kind;
        int len;
        int count;
        int done;
        case ($urandom_range(0, 5))
            0: pay = 16'd0;
            1: pay = 16'd1;
            2: pay = 16'hFFFF;
            default: pay = 16'($urandom_range(2, 9));
        endcase
        case ($urandom_range(0, 7))
            0: pkts = 16'd0;
            1: pkts = 16'hFFFF;
            2: pkts = 16'($urandom_range(1, 2));
            default: pkts = 16'($urandom_range(3, 8));
        endcase
        if (phase == 1)
            pay = 16'hFFFF;
        if (phase == 3)
            pkts = 16'd0;
        apply_settings({24'($urandom), pay}, {24'($urandom), pkts}, pick_addr(), pick_addr(),
                       {24'($urandom), 16'($urandom)});
        done = 0;
        while (done < PHASE_ITEMS) begin
            kind = $urandom_range(0, 9);
            case (kind)
                0: begin
                    count = $urandom_range(1, 3);
                    queue_bytes(1'b0, '0, count);
                end
                1: begin
                    len = $urandom_range(0, 30);
                    count = (len == 0) ? 1 : $urandom_range(1, len);
                    queue_bytes(1'b1, 24'(len), count);
                end
                2: begin
                    count = $urandom_range(1, 6);
                    queue_bytes(1'b1, 24'($urandom), count);
                end
                3: begin
                    len = $urandom_range(1, 10);
                    count = len + $urandom_range(1, 3);
                    queue_bytes(1'b1, 24'(len), count);
                end
                default: begin
                    len = $urandom_range(1, 24);
                    count = len;
                    queue_bytes(1'b1, 24'(len), count);
                end
            endcase
            done += count;
        end
        drain();
    endtask

    initial begin
        int phase;
        pk_cfg.payload_limit = 16'd1024;
        pk_cfg.max_packets = 16'hFFFF;
        pk_cfg.source_address = '0;
        pk_cfg.destination_address = '0;
        pk_cfg.header_flags = '0;
        bytes_left = '0;
        frag_left = '0;
        frag_offset = '0;
        packets_made = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // defaults, complete message, trailing bytes, empty and huge messages
        queue_bytes(1'b1, 24'd3, 3);
        queue_bytes(1'b0, '0, 2);
        queue_bytes(1'b1, 24'd0, 1);
        queue_bytes(1'b1, 24'hFFFFFF, 2);
        drain();

        // all-ones fields and checksum wrap, packet limit cuts the message
        for (int idx = REG_SPARE_LO; idx <= REG_SPARE_HI; idx++)
            write_reg(3'(idx), '1);
        apply_settings({24'hFFFFFF, 16'd4}, 40'd3, '1, '1, 40'hFFFF);
        queue_bytes(1'b1, 24'd14, 14);
        drain();

        // zero payload limit, then a settings change in the middle of a message
        apply_settings(40'd0, 40'hFFFF, '0, '0, '0);
        queue_bytes(1'b1, 24'd3, 2);
        drain();
        write_reg(REG_HDR_FLAGS, 40'h00A5);
        write_reg(REG_MAX_PAYLOAD, 40'd2);
        cfg_valid <= 1'b0;
        queue_bytes(1'b0, '0, 1);
        drain();

        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            bursts_on = (phase != 4) && (phase != RANDOM_PHASES - 1);
            random_phase(phase);
        end

        $display("covered %0d message bytes in %0d messages over %0d register settings",
                 items_accepted, messages_started, settings_applied);
        $display("checked %0d packet bytes across %0d packets", bytes_checked,
                 headers_predicted);
        if (mismatches == 0)
            $display("[message_packetizer] OK");
        else
            $display("[message_packetizer] ERROR");
        $finish;
    end
endmodule
